>>> rtl/ffha_pkg.sv
package ffha_pkg;

   localparam int unsigned ARENA_BYTES_DEF = 16384;
   localparam int unsigned GRANULE_BYTES   = 8;

   // Field widths of the request and response transactions
   localparam int unsigned OPCODE_W = 2;
   localparam int unsigned OFFSET_W = 14;
   localparam int unsigned REQ_W    = 15;
   localparam int unsigned COUNT_W  = 12;
   localparam int unsigned BYTES_W  = 14;
   // Byte fields hold granule counts shifted left by three
   localparam int unsigned GRAN_W   = BYTES_W - 3;
   localparam int unsigned NEED_W   = REQ_W - 2;

   typedef enum logic [OPCODE_W-1:0] {
      OP_ALLOC  = 2'd0,
      OP_STATS  = 2'd1,
      OP_REINIT = 2'd2,
      OP_NONE   = 2'd3
   } opcode_type;

endpackage

>>> rtl/first_fit_heap_allocator_top.sv
// Allocate walks the chain one header per cycle until the first fit, then goes to the split step;
// free walks from the arena start to the freed header; a move does both; statistics walks the chain.
// Throughput: one transaction in flight; the header RAM's single read port paces every walk step.
// Reset: synchronous; after reset S_INIT writes the whole-arena free header, then ready.
// Offsets beyond arenas below 16 KiB wrap by repeated subtraction of the arena size in S_MOD.
module first_fit_heap_allocator_top #(
   parameter int unsigned ARENA_BYTES = ffha_pkg::ARENA_BYTES_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [ffha_pkg::OPCODE_W-1:0]  req_opcode,
   input  logic [ffha_pkg::OFFSET_W-1:0]  req_block_offset,
   input  logic [ffha_pkg::REQ_W-1:0]     req_request_size,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic                           rsp_status,
   output logic [ffha_pkg::OFFSET_W-1:0]  rsp_result_offset,
   output logic [ffha_pkg::OFFSET_W-1:0]  rsp_copy_source,
   output logic [ffha_pkg::BYTES_W-1:0]   rsp_copy_length,
   output logic [ffha_pkg::COUNT_W-1:0]   rsp_block_count,
   output logic [ffha_pkg::BYTES_W-1:0]   rsp_used_bytes,
   output logic [ffha_pkg::BYTES_W-1:0]   rsp_free_bytes,
   output logic [ffha_pkg::COUNT_W-1:0]   rsp_free_block_count,
   output logic [ffha_pkg::BYTES_W-1:0]   rsp_largest_free_bytes
);

   // Everything internal counts in 8-byte granules. A header entry is {used, size}.
   localparam int unsigned NG = ARENA_BYTES / ffha_pkg::GRANULE_BYTES;
   localparam int unsigned GW = $clog2(NG);
   // Wide enough for h + 1 + size (< 2*NG) and for the rounded request size
   localparam int unsigned CW = (GW + 2 > ffha_pkg::NEED_W + 1) ? GW + 2 : ffha_pkg::NEED_W + 1;
   localparam int unsigned LW = (GW + 3 > ffha_pkg::REQ_W) ? GW + 3 : ffha_pkg::REQ_W;
   localparam int unsigned XW = ffha_pkg::OFFSET_W - 3;
   localparam int unsigned AW = ffha_pkg::GRAN_W;
   localparam logic [CW-1:0] NG_C   = CW'(NG);
   localparam logic [GW-1:0] MAX_SZ = GW'(NG - 1);

   typedef enum logic [4:0] {
      S_INIT, S_IDLE, S_REINIT, S_MOD, S_ST_RD, S_ST_USE, S_RE_RD, S_RE_H, S_RE_N,
      S_MV, S_AL_RD, S_AL_USE, S_SP_CHK, S_SP_A, S_SP_H, S_SP_RET,
      S_FR_RD, S_FR_H, S_FR_N, S_FW_RD, S_FW_USE, S_FW_MRG, S_DONE
   } state_type;

   state_type state_ff;

   // Header RAM: one write and one read per cycle, read data registered
   logic [GW:0]   mem_ff [NG];
   logic [GW:0]   rd_data_ff;
   logic [GW-1:0] rd_addr_c;
   logic          wr_en_c;
   logic [CW-1:0] wr_addr_c;
   logic [GW:0]   wr_data_c;

   logic          rd_used;
   logic [GW-1:0] rd_size;
   assign rd_used = rd_data_ff[GW];
   assign rd_size = rd_data_ff[GW-1:0];

   // Sequencer registers
   logic [CW-1:0]               cur_ff;    // header under work
   logic [CW-1:0]               old_ff;    // block being moved away from
   logic [CW-1:0]               walk_ff;   // chain walk pointer
   logic [ffha_pkg::NEED_W-1:0] need_ff;
   logic [ffha_pkg::REQ_W-1:0]  rq_ff;
   logic [XW-1:0]               x_ff;
   logic [GW-1:0]               s_ff;
   logic                        u_ff;
   logic                        nv_ff;
   logic                        move_ff;
   logic                        free_tgt_ff;

   // Result accumulators
   logic                         status_ff;
   logic [AW-1:0]                res_ff;
   logic [AW-1:0]                csrc_ff;
   logic [ffha_pkg::BYTES_W-1:0] clen_ff;
   logic [ffha_pkg::COUNT_W-1:0] cnt_ff;
   logic [ffha_pkg::COUNT_W-1:0] fcnt_ff;
   logic [AW-1:0]                ub_ff;
   logic [AW-1:0]                fb_ff;
   logic [GW-1:0]                big_ff;

   // Response register
   logic                         rsp_valid_ff;
   logic                         rsp_status_ff;
   logic [ffha_pkg::OFFSET_W-1:0] rsp_result_offset_ff;
   logic [ffha_pkg::OFFSET_W-1:0] rsp_copy_source_ff;
   logic [ffha_pkg::BYTES_W-1:0] rsp_copy_length_ff;
   logic [ffha_pkg::COUNT_W-1:0] rsp_block_count_ff;
   logic [ffha_pkg::BYTES_W-1:0] rsp_used_bytes_ff;
   logic [ffha_pkg::BYTES_W-1:0] rsp_free_bytes_ff;
   logic [ffha_pkg::COUNT_W-1:0] rsp_free_block_count_ff;
   logic [ffha_pkg::BYTES_W-1:0] rsp_largest_free_bytes_ff;

   // Shared step unit: a + b + 1, the next-header / merge adder
   logic [CW-1:0] a_c;
   logic [CW-1:0] b_c;
   logic [CW-1:0] nxt_c;
   logic          nxt_ok_c;
   logic [CW-1:0] ns_c;
   logic [ffha_pkg::REQ_W:0] rnd_c;
   logic [LW-1:0] sbytes_c;

   assign nxt_c    = a_c + b_c + CW'(1);
   assign nxt_ok_c = nxt_c < NG_C;
   assign rnd_c    = {1'b0, req_request_size} + (ffha_pkg::REQ_W + 1)'(7);
   assign sbytes_c = LW'({s_ff, 3'b000});

   function automatic logic [GW-1:0] sat_f(input logic [CW-1:0] v);
      logic [GW-1:0] r;
      r = (v > CW'(NG - 1)) ? MAX_SZ : v[GW-1:0];
      return r;
   endfunction

   // Remainder of the split block, plus the free block behind it
   assign ns_c = CW'(s_ff) - CW'(need_ff) - CW'(1)
               + ((nv_ff && !rd_used) ? CW'(rd_size) + CW'(1) : CW'(0));

   always_comb begin
      a_c       = cur_ff;
      b_c       = CW'(rd_size);
      rd_addr_c = cur_ff[GW-1:0];
      wr_en_c   = 1'b0;
      wr_addr_c = cur_ff;
      wr_data_c = {1'b0, MAX_SZ};
      unique case (state_ff)
         S_INIT, S_REINIT: begin
            wr_en_c   = 1'b1;
            wr_addr_c = '0;
         end
         S_ST_RD, S_FW_RD: begin
            rd_addr_c = walk_ff[GW-1:0];
         end
         S_ST_USE: begin
            a_c       = walk_ff;
            rd_addr_c = nxt_c[GW-1:0];
         end
         S_FW_USE: begin
            a_c       = walk_ff;
            rd_addr_c = (nxt_c == cur_ff) ? walk_ff[GW-1:0] : nxt_c[GW-1:0];
         end
         S_AL_USE, S_RE_H: begin
            rd_addr_c = nxt_c[GW-1:0];
         end
         S_FR_H: begin
            rd_addr_c = nxt_c[GW-1:0];
            wr_en_c   = 1'b1;
            wr_data_c = {1'b0, rd_size};
         end
         S_RE_N: begin
            a_c = CW'(s_ff);
            if (!rd_used && nxt_c >= CW'(need_ff)) begin
               wr_en_c   = 1'b1;
               wr_data_c = {u_ff, sat_f(nxt_c)};
            end
         end
         S_FR_N: begin
            a_c = CW'(s_ff);
            if (nv_ff && !rd_used) begin
               wr_en_c   = 1'b1;
               wr_data_c = {1'b0, sat_f(nxt_c)};
            end
         end
         S_FW_MRG: begin
            a_c = CW'(s_ff);
            if (!rd_used) begin
               wr_en_c   = 1'b1;
               wr_addr_c = walk_ff;
               wr_data_c = {1'b0, sat_f(nxt_c)};
            end
         end
         S_SP_CHK: begin
            b_c       = CW'(s_ff);
            rd_addr_c = nxt_c[GW-1:0];
            if (CW'(s_ff) < CW'(need_ff) + CW'(2)) begin
               wr_en_c   = 1'b1;
               wr_data_c = {u_ff, s_ff};
            end
         end
         S_SP_A: begin
            b_c = CW'(need_ff);
            if (nxt_ok_c) begin
               wr_en_c   = 1'b1;
               wr_addr_c = nxt_c;
               wr_data_c = {1'b0, sat_f(ns_c)};
            end
         end
         S_SP_H: begin
            wr_en_c   = 1'b1;
            wr_data_c = {u_ff, GW'(need_ff)};
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en_c) begin
         mem_ff[wr_addr_c[GW-1:0]] <= wr_data_c;
      end
      rd_data_ff <= mem_ff[rd_addr_c];
   end

   assign req_stall = (state_ff != S_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         // the done state reloads the response register itself
         if (rsp_valid_ff && !rsp_stall && state_ff != S_DONE) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_INIT, S_REINIT: begin
               state_ff <= (state_ff == S_INIT) ? S_IDLE : S_DONE;
            end
            S_IDLE: begin
               if (req_valid) begin
                  x_ff        <= req_block_offset[ffha_pkg::OFFSET_W-1:3] - XW'(1);
                  need_ff     <= rnd_c[ffha_pkg::REQ_W:3];
                  rq_ff       <= req_request_size;
                  move_ff     <= 1'b0;
                  status_ff   <= 1'b0;
                  res_ff      <= '0;
                  csrc_ff     <= '0;
                  clen_ff     <= '0;
                  cnt_ff      <= '0;
                  fcnt_ff     <= '0;
                  ub_ff       <= '0;
                  fb_ff       <= '0;
                  big_ff      <= '0;
                  walk_ff     <= '0;
                  cur_ff      <= '0;
                  unique case (ffha_pkg::opcode_type'(req_opcode))
                     ffha_pkg::OP_ALLOC: begin
                        free_tgt_ff <= (req_request_size == '0);
                        priority if (req_block_offset[ffha_pkg::OFFSET_W-1:3] != '0) begin
                           state_ff <= S_MOD;
                        end else if (req_request_size == '0) begin
                           state_ff <= S_DONE;
                        end else begin
                           state_ff <= S_AL_RD;
                        end
                     end
                     ffha_pkg::OP_STATS:  state_ff <= S_ST_RD;
                     ffha_pkg::OP_REINIT: state_ff <= S_REINIT;
                     ffha_pkg::OP_NONE:   state_ff <= S_DONE;
                     default:             state_ff <= S_DONE;
                  endcase
               end
            end
            S_MOD: begin
               if (CW'(x_ff) >= NG_C) begin
                  x_ff <= XW'(CW'(x_ff) - NG_C);
               end else begin
                  cur_ff   <= CW'(x_ff);
                  state_ff <= free_tgt_ff ? S_FR_RD : S_RE_RD;
               end
            end
            S_ST_RD: state_ff <= S_ST_USE;
            S_ST_USE: begin
               cnt_ff <= cnt_ff + ffha_pkg::COUNT_W'(1);
               if (rd_used) begin
                  ub_ff <= ub_ff + AW'(rd_size);
               end else begin
                  fcnt_ff <= fcnt_ff + ffha_pkg::COUNT_W'(1);
                  fb_ff   <= fb_ff + AW'(rd_size);
                  if (rd_size > big_ff) begin
                     big_ff <= rd_size;
                  end
               end
               if (nxt_ok_c) begin
                  walk_ff <= nxt_c;
               end else begin
                  state_ff <= S_DONE;
               end
            end
            S_RE_RD: state_ff <= S_RE_H;
            S_RE_H: begin
               s_ff <= rd_size;
               u_ff <= rd_used;
               priority if (CW'(rd_size) >= CW'(need_ff)) begin
                  state_ff <= S_SP_CHK;
               end else if (nxt_ok_c) begin
                  state_ff <= S_RE_N;
               end else begin
                  state_ff <= S_MV;
               end
            end
            S_RE_N: begin
               if (!rd_used && nxt_c >= CW'(need_ff)) begin
                  s_ff     <= sat_f(nxt_c);
                  state_ff <= S_SP_CHK;
               end else begin
                  state_ff <= S_MV;
               end
            end
            S_MV: begin
               // copy length is the smaller of old payload and new request
               move_ff  <= 1'b1;
               old_ff   <= cur_ff;
               cur_ff   <= '0;
               clen_ff  <= (sbytes_c < LW'(rq_ff)) ? ffha_pkg::BYTES_W'(sbytes_c)
                                                    : ffha_pkg::BYTES_W'(rq_ff);
               state_ff <= S_AL_RD;
            end
            S_AL_RD: state_ff <= S_AL_USE;
            S_AL_USE: begin
               priority if (!rd_used && CW'(rd_size) >= CW'(need_ff)) begin
                  s_ff     <= rd_size;
                  u_ff     <= 1'b1;
                  state_ff <= S_SP_CHK;
               end else if (nxt_ok_c) begin
                  cur_ff <= nxt_c;
               end else begin
                  status_ff <= 1'b1;
                  clen_ff   <= '0;
                  state_ff  <= S_DONE;
               end
            end
            S_SP_CHK: begin
               nv_ff    <= nxt_ok_c;
               state_ff <= (CW'(s_ff) < CW'(need_ff) + CW'(2)) ? S_SP_RET : S_SP_A;
            end
            S_SP_A: state_ff <= S_SP_H;
            S_SP_H: state_ff <= S_SP_RET;
            S_SP_RET: begin
               res_ff <= AW'(cur_ff + CW'(1));
               if (move_ff) begin
                  csrc_ff  <= AW'(old_ff + CW'(1));
                  cur_ff   <= old_ff;
                  state_ff <= S_FR_RD;
               end else begin
                  state_ff <= S_DONE;
               end
            end
            S_FR_RD: state_ff <= S_FR_H;
            S_FR_H: begin
               s_ff     <= rd_size;
               nv_ff    <= nxt_ok_c;
               state_ff <= S_FR_N;
            end
            S_FR_N: begin
               if (nv_ff && !rd_used) begin
                  s_ff <= sat_f(nxt_c);
               end
               walk_ff  <= '0;
               state_ff <= S_FW_RD;
            end
            S_FW_RD: state_ff <= S_FW_USE;
            S_FW_USE: begin
               priority if (!nxt_ok_c) begin
                  state_ff <= S_DONE;
               end else if (nxt_c == cur_ff) begin
                  state_ff <= S_FW_MRG;
               end else begin
                  walk_ff <= nxt_c;
               end
            end
            S_FW_MRG: state_ff <= S_DONE;
            S_DONE: begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_valid_ff              <= 1'b1;
                  rsp_status_ff             <= status_ff;
                  rsp_result_offset_ff      <= {res_ff, 3'b000};
                  rsp_copy_source_ff        <= {csrc_ff, 3'b000};
                  rsp_copy_length_ff        <= clen_ff;
                  rsp_block_count_ff        <= cnt_ff;
                  rsp_used_bytes_ff         <= {ub_ff, 3'b000};
                  rsp_free_bytes_ff         <= {fb_ff, 3'b000};
                  rsp_free_block_count_ff   <= fcnt_ff;
                  rsp_largest_free_bytes_ff <= {AW'(big_ff), 3'b000};
                  state_ff                  <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_status             = rsp_status_ff;
   assign rsp_result_offset      = rsp_result_offset_ff;
   assign rsp_copy_source        = rsp_copy_source_ff;
   assign rsp_copy_length        = rsp_copy_length_ff;
   assign rsp_block_count        = rsp_block_count_ff;
   assign rsp_used_bytes         = rsp_used_bytes_ff;
   assign rsp_free_bytes         = rsp_free_bytes_ff;
   assign rsp_free_block_count   = rsp_free_block_count_ff;
   assign rsp_largest_free_bytes = rsp_largest_free_bytes_ff;

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("accepted a transaction without going busy");

   a_write_in_arena: assert property (@(posedge clock) disable iff (reset)
      wr_en_c |-> (wr_addr_c < NG_C))
      else $error("header write outside the arena");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_DONE))
      else $error("response loaded outside the done state");

   a_fail_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff) |->
         (rsp_result_offset_ff == '0 && rsp_copy_length_ff == '0))
      else $error("no-space response carries an offset or copy length");

endmodule
